// ===== design/gf2h_pkg.sv =====
// shared constants for the gf2 polynomial remainder hash
// no dependencies; imported by the interfaces and every module
`timescale 1ns / 1ps

package gf2h_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int CFG_W         = 32;
    localparam int FP_W          = 32;
    localparam int POS_W         = 6;
    localparam int EXT_W         = 64;

    localparam logic [POS_W-1:0] POS_MAX = '1;

endpackage

// ===== design/gf2h_if.sv =====
// request, result and configuration channels of the gf2 remainder hash
// depends on gf2h_pkg for field widths
`timescale 1ns / 1ps

interface gf2h_msg_if
    import gf2h_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [BITS_PER_BYTE-1:0] data_byte;
    logic                     last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gf2h_hash_if
    import gf2h_pkg::*;
    ();
    logic            valid;
    logic            ready;
    logic [FP_W-1:0] fingerprint;

    modport source (output valid, output fingerprint, input ready);
    modport sink   (input valid, input fingerprint, output ready);
endinterface

interface gf2h_cfg_if
    import gf2h_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] modulus_poly;

    modport source (output valid, output modulus_poly, input ready);
    modport sink   (input valid, input modulus_poly, output ready);
endinterface

// ===== design/gf2h_poly_decode.sv =====
// priority encoder on the modulus: degree, top-bit mask and low terms
// depends on gf2h_pkg
`timescale 1ns / 1ps

module gf2h_poly_decode
    import gf2h_pkg::*;
#(
    parameter int POLY_WIDTH = 32
) (
    input  logic [POLY_WIDTH-1:0] poly,
    output logic [POS_W-1:0]      degree,
    output logic [POLY_WIDTH-1:0] top_mask,
    output logic [POLY_WIDTH-1:0] low_terms
);

    localparam logic [POLY_WIDTH-1:0] ONE = POLY_WIDTH'(1);

    always_comb
    begin
        degree = '0;
        for (int i = 0; i < POLY_WIDTH; i++)
        begin
            if (poly[i])
            begin
                degree = POS_W'(i);
            end
        end
    end

    // a zero modulus decodes as degree 0 with no low terms
    assign top_mask  = ONE << degree;
    assign low_terms = poly & ~top_mask;

endmodule

// ===== design/gf2h_byte_step.sv =====
// eight shift-and-reduce steps for one message byte, lsb first
// depends on gf2h_pkg
`timescale 1ns / 1ps

module gf2h_byte_step
    import gf2h_pkg::*;
#(
    parameter int POLY_WIDTH = 32
) (
    input  logic [BITS_PER_BYTE-1:0] data_byte,
    input  logic [POS_W-1:0]         degree,
    input  logic [POLY_WIDTH-1:0]    top_mask,
    input  logic [POLY_WIDTH-1:0]    low_terms,
    input  logic [POLY_WIDTH-1:0]    acc,
    input  logic [POLY_WIDTH-1:0]    power,
    input  logic [POS_W-1:0]         pos,
    output logic [POLY_WIDTH-1:0]    acc_out,
    output logic [POLY_WIDTH-1:0]    power_out,
    output logic [POS_W-1:0]         pos_out
);

    localparam logic [POLY_WIDTH-1:0] ONE = POLY_WIDTH'(1);

    always_comb
    begin
        logic [POLY_WIDTH-1:0] a;
        logic [POLY_WIDTH-1:0] p;
        logic [POS_W-1:0]      k;
        a = acc;
        p = power;
        k = pos;
        for (int j = 0; j < BITS_PER_BYTE; j++)
        begin
            if (k >= degree)
            begin
                if (data_byte[j])
                begin
                    a = a ^ p;
                end
                p = p << 1;
                if ((p & top_mask) != '0)
                begin
                    p = p ^ top_mask ^ low_terms;
                end
            end
            else if (data_byte[j])
            begin
                // bits below the degree are copied as they are
                a = a | (ONE << k);
            end
            if (k != POS_MAX)
            begin
                k = k + POS_W'(1);
            end
        end
        acc_out   = a;
        power_out = p;
        pos_out   = k;
    end

endmodule

// ===== design/gf2_polynomial_remainder_hash.sv =====
// gf2 polynomial remainder hash, one message byte per request
// result: the last byte passes from the request register into the result register once that
//   register is free; the fingerprint is then valid on the result channel
// throughput: one byte per cycle while no last byte waits on a stalled result; set by the
//   eight-step byte reduction between the request register and the message state
// reset: modulus 1, message state cleared; a modulus write also clears the message
`timescale 1ns / 1ps

module gf2_polynomial_remainder_hash
    import gf2h_pkg::*;
#(
    parameter int POLY_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    gf2h_cfg_if.sink     cfg,
    gf2h_msg_if.sink     msg,
    gf2h_hash_if.source  hash
);

    localparam logic [POLY_WIDTH-1:0] ONE = POLY_WIDTH'(1);

    // modulus and its decoded form
    logic [POLY_WIDTH-1:0] poly_reg;
    logic [POS_W-1:0]      degree_reg;
    logic [POLY_WIDTH-1:0] top_reg;
    logic [POLY_WIDTH-1:0] low_reg;

    // message state
    logic [POLY_WIDTH-1:0] acc_reg;
    logic [POLY_WIDTH-1:0] power_reg;
    logic [POS_W-1:0]      pos_reg;

    // request register
    logic                     s1_valid_reg;
    logic [BITS_PER_BYTE-1:0] s1_byte_reg;
    logic                     s1_last_reg;

    // result register
    logic            out_valid_reg;
    logic [FP_W-1:0] fp_reg;

    logic [POLY_WIDTH-1:0] poly_next;
    logic [POS_W-1:0]      degree_next;
    logic [POLY_WIDTH-1:0] top_next;
    logic [POLY_WIDTH-1:0] low_next;
    logic [POLY_WIDTH-1:0] acc_next;
    logic [POLY_WIDTH-1:0] power_next;
    logic [POS_W-1:0]      pos_next;
    logic [EXT_W-1:0]      acc_ext;

    logic cfg_fire;
    logic msg_fire;
    logic out_free;
    logic s1_adv;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign poly_next = POLY_WIDTH'(cfg.modulus_poly);

    assign out_free  = !out_valid_reg || hash.ready;
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || out_free);
    assign msg.ready = !s1_valid_reg || s1_adv;
    assign msg_fire  = msg.valid && msg.ready;

    assign hash.valid       = out_valid_reg;
    assign hash.fingerprint = fp_reg;

    gf2h_poly_decode #(
        .POLY_WIDTH (POLY_WIDTH)
    ) u_decode (
        .poly      (poly_next),
        .degree    (degree_next),
        .top_mask  (top_next),
        .low_terms (low_next)
    );

    gf2h_byte_step #(
        .POLY_WIDTH (POLY_WIDTH)
    ) u_step (
        .data_byte (s1_byte_reg),
        .degree    (degree_reg),
        .top_mask  (top_reg),
        .low_terms (low_reg),
        .acc       (acc_reg),
        .power     (power_reg),
        .pos       (pos_reg),
        .acc_out   (acc_next),
        .power_out (power_next),
        .pos_out   (pos_next)
    );

    assign acc_ext = EXT_W'(acc_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg   <= ONE;
            degree_reg <= '0;
            top_reg    <= ONE;
            low_reg    <= '0;
            acc_reg    <= '0;
            power_reg  <= '0;
            pos_reg    <= '0;
        end
        else if (cfg_fire)
        begin
            poly_reg   <= poly_next;
            degree_reg <= degree_next;
            top_reg    <= top_next;
            low_reg    <= low_next;
            acc_reg    <= '0;
            power_reg  <= low_next;
            pos_reg    <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                // end of message: restart from the modulus low terms
                acc_reg   <= '0;
                power_reg <= poly_reg & ~top_reg;
                pos_reg   <= '0;
            end
            else
            begin
                acc_reg   <= acc_next;
                power_reg <= power_next;
                pos_reg   <= pos_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (msg.ready)
        begin
            s1_valid_reg <= msg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_fire)
        begin
            s1_byte_reg <= msg.data_byte;
            s1_last_reg <= msg.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (hash.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            fp_reg <= acc_ext[FP_W-1:0];
        end
    end

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (pos_reg == '0) && (acc_reg == '0))
        else $error("message state not cleared after modulus write");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg && !cfg_fire) |=> (pos_reg == '0) && (acc_reg == '0))
        else $error("message state not cleared after last byte");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=> out_valid_reg)
        else $error("last byte did not produce a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hash.ready && s1_valid_reg && s1_last_reg) |-> !s1_adv)
        else $error("pending result overwritten");

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for gf2_polynomial_remainder_hash: byte requests with random pacing,
// a stalling result side, and a fingerprint scoreboard with its own polynomial arithmetic
// depends on gf2h_pkg, the gf2h interfaces and the design top
`timescale 1ns / 1ps

module tb_top;
    import gf2h_pkg::*;

    localparam int RANDOM_ITEMS  = 1500;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 300000;

    class fingerprint_board;
        logic [CFG_W-1:0] modulus;
        logic [CFG_W-1:0] top_term;
        logic [CFG_W-1:0] low_terms;
        logic [CFG_W-1:0] remainder;
        logic [CFG_W-1:0] power;
        logic [POS_W-1:0] bit_pos;
        int unsigned      degree;
        logic [FP_W-1:0]  expected_fp[$];
        int               errors;

        function new();
            errors = 0;
            set_modulus(CFG_W'(1));
        endfunction

        function void clear_message();
            remainder = '0;
            bit_pos   = '0;
            power     = low_terms;
        endfunction

        // zero modulus ends up as degree 0 with no low terms
        function void set_modulus(logic [CFG_W-1:0] m);
            modulus = m;
            degree  = 0;
            for (int i = 0; i < CFG_W; i++)
            begin
                if (m[i])
                    degree = i;
            end
            top_term  = CFG_W'(1) << degree;
            low_terms = m & ~top_term;
            clear_message();
        endfunction

        function void note_request(logic [BITS_PER_BYTE-1:0] b, logic last);
            for (int j = 0; j < BITS_PER_BYTE; j++)
            begin
                if (bit_pos >= degree)
                begin
                    if (b[j])
                        remainder ^= power;
                    power = power << 1;
                    if ((power & top_term) != '0)
                        power = power ^ top_term ^ low_terms;
                end
                else if (b[j])
                begin
                    remainder[bit_pos] = 1'b1;
                end
                if (bit_pos != POS_MAX)
                    bit_pos++;
            end
            if (last)
            begin
                expected_fp.push_back(remainder[FP_W-1:0]);
                clear_message();
            end
        endfunction

        function void check_fp(logic [FP_W-1:0] fp);
            logic [FP_W-1:0] want;
            if (expected_fp.size() == 0)
            begin
                $error("fingerprint: expected none, actual %h", fp);
                errors++;
                return;
            end
            want = expected_fp.pop_front();
            if (fp !== want)
            begin
                $error("fingerprint: expected %h, actual %h", want, fp);
                errors++;
            end
        endfunction

        function int pending();
            return expected_fp.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gf2h_cfg_if  cfg_ch ();
    gf2h_msg_if  msg_ch ();
    gf2h_hash_if hash_ch ();

    gf2_polynomial_remainder_hash uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .msg   (msg_ch),
        .hash  (hash_ch)
    );

    fingerprint_board board = new();
    int unsigned      cycle_count = 0;
    int unsigned      burst_left  = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // monitors: predict on accepted writes and requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                board.set_modulus(cfg_ch.modulus_poly);
            if (msg_ch.valid && msg_ch.ready)
                board.note_request(msg_ch.data_byte, msg_ch.last_byte);
            if (hash_ch.valid && hash_ch.ready)
                board.check_fp(hash_ch.fingerprint);
        end
    end

    // result side stalls: free-running, pattern-driven, or mostly stalled
    int unsigned stall_mode  = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_index = 0;
    logic [31:0] stall_bits;
    logic [31:0] stall_mask;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 200);
            stall_bits = $urandom;
            stall_mask = $urandom;
        end
        stall_left--;
        stall_index = (stall_index + 1) % 32;
        case (stall_mode)
            0:       hash_ch.ready <= 1'b1;
            3:       hash_ch.ready <= stall_bits[stall_index] & stall_mask[stall_index];
            default: hash_ch.ready <= stall_bits[stall_index];
        endcase
    end

    // bursts of random length separated by random gaps
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                msg_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic push_byte(input logic [BITS_PER_BYTE-1:0] b, input logic last);
        pace_sender();
        msg_ch.valid     <= 1'b1;
        msg_ch.data_byte <= b;
        msg_ch.last_byte <= last;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
    endtask

    // hold requests until every fingerprint is out and the pipeline has settled
    task automatic wait_idle();
        msg_ch.valid <= 1'b0;
        // let the monitor note the last accepted request first
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [CFG_W-1:0] m);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.modulus_poly <= m;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_modulus();
        int unsigned d;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'(1);
            2: return '1;
            3: return CFG_W'(1) << (CFG_W - 1);
            4, 5: return $urandom;
            default:
            begin
                d = $urandom_range(1, CFG_W - 1);
                return ($urandom & ((CFG_W'(1) << d) - 1)) | (CFG_W'(1) << d);
            end
        endcase
    endfunction

    task automatic push_message(input int unsigned len);
        for (int i = 0; i < len; i++)
            push_byte(BITS_PER_BYTE'($urandom_range(0, 255)), i == len - 1);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned len;

        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.modulus_poly = '0;
        msg_ch.valid        = 1'b0;
        msg_ch.data_byte    = '0;
        msg_ch.last_byte    = 1'b0;
        hash_ch.ready       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modulus 1 reduces everything to zero
        push_byte(8'hFF, 1'b1);

        wait_idle();
        write_modulus('0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'hFF, 1'b1);

        // all-ones modulus: degree 31, the first 31 bits copy straight through
        wait_idle();
        write_modulus('1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b1);

        // low-degree modulus and a message long enough to saturate the bit counter
        wait_idle();
        write_modulus(32'h0000_008D);
        push_message(10);

        // modulus change mid-message drops the partial message
        push_byte(8'h3C, 1'b0);
        push_byte(8'hC3, 1'b0);
        wait_idle();
        write_modulus(CFG_W'(1) << (CFG_W - 1));
        push_byte(8'hFF, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            write_modulus(pick_modulus());
            repeat ($urandom_range(3, 15))
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                push_message(len);
                sent += len;
            end
            // sometimes leave a message open so the next write drops it
            if ($urandom_range(0, 3) == 0)
            begin
                len = $urandom_range(1, 5);
                repeat (len) push_byte(BITS_PER_BYTE'($urandom_range(0, 255)), 1'b0);
                sent += len;
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== gf2_polynomial_remainder_hash.f =====
design/gf2h_pkg.sv
design/gf2h_if.sv
design/gf2h_poly_decode.sv
design/gf2h_byte_step.sv
design/gf2_polynomial_remainder_hash.sv
bench/tb_top.sv
